// ----- hdl/uvs_pkg.sv -----
// uv sphere tessellator shared types, constants and division tables
// no dependencies; used by uv_sphere_tessellator, uvs_phase and uvs_sine
`timescale 1ns / 1ps
package uvs_pkg;

    localparam int MAX_PRECISION   = 255;
    localparam int COORD_FRAC_BITS = 14;

    localparam logic [7:0]  PRECISION_RESET = 8'd30;
    localparam logic [30:0] Q30_ONE         = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [16:0] TEX_MAX         = 17'h1_FFFF;
    localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;

    localparam int HORNER_STEPS = 6;
    localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};

    localparam int PHASE_LAT = 7;
    localparam int SINE_LAT  = 25;

    typedef logic [32:0] quot_tab_t [256];
    typedef logic [7:0]  rem_tab_t  [256];

    // long division of 2^k by d, quotient or remainder
    function automatic longint unsigned pow2_div(input int k, input int d, input bit want_rem);
        longint unsigned r;
        longint unsigned q;
        r = 64'd0;
        q = 64'd0;
        for (int b = k; b >= 0; b--)
        begin
            r = (r << 1) | ((b == k) ? 64'd1 : 64'd0);
            q = q << 1;
            if (r >= 64'(d))
            begin
                r = r - 64'(d);
                q = q | 64'd1;
            end
        end
        return want_rem ? r : q;
    endfunction

    // floor(2^k / p) for every precision code p from 1 to 255; entry 0 is zero
    function automatic quot_tab_t build_quot(input int k);
        quot_tab_t tab;
        tab[0] = '0;
        for (int i = 1; i < 256; i++)
        begin
            tab[i] = 33'(pow2_div(k, i, 1'b0));
        end
        return tab;
    endfunction

    // 2^k mod p for every precision code p from 1 to 255; entry 0 is zero
    function automatic rem_tab_t build_rem(input int k);
        rem_tab_t tab;
        tab[0] = '0;
        for (int i = 1; i < 256; i++)
        begin
            tab[i] = 8'(pow2_div(k, i, 1'b1));
        end
        return tab;
    endfunction

    localparam quot_tab_t QUOT32 = build_quot(32);
    localparam quot_tab_t QUOT31 = build_quot(31);
    localparam quot_tab_t QUOT16 = build_quot(16);
    localparam rem_tab_t  REM32  = build_rem(32);
    localparam rem_tab_t  REM31  = build_rem(31);
    localparam rem_tab_t  REM16  = build_rem(16);

    typedef struct packed {
        logic [31:0] theta;
        logic [31:0] phi;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } phase_t;

    typedef struct packed {
        logic [30:0] mag;
        logic        neg;
    } sine_t;

    typedef struct packed {
        logic        quad_valid;
        logic [15:0] tri0_a;
        logic [15:0] tri0_b;
        logic [15:0] tri0_c;
        logic [15:0] tri1_c;
    } index_t;

endpackage

// ----- hdl/uv_sphere_tessellator.sv -----
// uv sphere tessellator top level: config register, valid pipeline, position and index output
// depends on uvs_pkg, uvs_phase, uvs_sine
//
// channel   | dir | beat contents
// s_axis    | in  | tdata: grid_row, grid_col
// m_axis    | out | tdata: pos_x, pos_y, pos_z, tex_u, tex_v, tri0_a..tri1_c; tuser: quad_valid
// cfg       | in  | cfg_we, cfg_wdata: precision
//
// one beat per cycle while no output beat is held; each beat passes the stages below to the output register
// 7 phase stages (table, multiply, four divider stages, sum), 25 sine stages
// (fold, angle scaling and squaring, six horner steps of three stages each, final product and clamp),
// 2 for the product and rounding; rst_n clears valid bits and sets precision to 30; no clearing pass
// the whole pipeline holds while an output beat waits; nothing is dropped or repeated
`timescale 1ns / 1ps
module uv_sphere_tessellator #(
    parameter int MAX_PRECISION   = uvs_pkg::MAX_PRECISION,
    parameter int COORD_FRAC_BITS = uvs_pkg::COORD_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // grid_row, grid_col
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [183:0] m_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v,
                                         // tri0_a, tri0_b, tri0_c, tri1_a, tri1_b, tri1_c, zero
    output logic         m_axis_tuser,   // quad_valid
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata
);

    localparam int LAT     = uvs_pkg::PHASE_LAT + uvs_pkg::SINE_LAT + 2;
    localparam int IDX_DLY = LAT - 1;
    localparam int TEX_DLY = uvs_pkg::SINE_LAT + 1;
    localparam int SHIFT   = 30 - COORD_FRAC_BITS;
    localparam logic [31:0] HALF = (32'd1 << SHIFT) >> 1;
    localparam logic [7:0]  MAXP = 8'(MAX_PRECISION);

    typedef struct packed {
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } tex_t;

    logic [7:0]       prec_reg;
    logic [7:0]       prec_eff;
    logic [LAT-1:0]   v_reg;
    logic             en;

    logic [7:0]       grid_row, grid_col;
    logic [8:0]       p_inc;
    logic [15:0]      a_idx, b_idx;
    logic             quad;
    uvs_pkg::index_t  idx_next;
    uvs_pkg::index_t  idx_dly [IDX_DLY];
    tex_t             tex_dly [TEX_DLY];

    uvs_pkg::phase_t  ph;
    uvs_pkg::sine_t   st, ct, sp, cp;

    logic [61:0]      mx_prod, mz_prod;
    logic [30:0]      mx_reg, mz_reg, my_reg;
    logic             nx_reg, nz_reg, ny_reg;
    logic [30:0]      mx_next, mz_next;

    function automatic logic [15:0] to_coord(input logic [30:0] mag, input logic neg);
        logic [31:0] v;
        v = (32'(mag) + HALF) >> SHIFT;
        if (neg)
        begin
            v = 32'd0 - v;
        end
        return v[15:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prec_reg <= uvs_pkg::PRECISION_RESET;
        end
        else if (cfg_we)
        begin
            prec_reg <= cfg_wdata;
        end
    end

    assign prec_eff = (prec_reg == 8'd0) ? 8'd1 : ((prec_reg > MAXP) ? MAXP : prec_reg);

    assign en            = !v_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    assign grid_row = s_axis_tdata[7:0];
    assign grid_col = s_axis_tdata[15:8];

    // vertex numbering row * (p + 1) + col
    assign p_inc = 9'(prec_eff) + 9'd1;
    assign a_idx = 16'(grid_row) * 16'(p_inc) + 16'(grid_col);
    assign b_idx = a_idx + 16'(p_inc);
    assign quad  = (grid_row < prec_eff) && (grid_col < prec_eff);

    always_comb
    begin
        idx_next = '0;
        if (quad)
        begin
            idx_next.quad_valid = 1'b1;
            idx_next.tri0_a     = a_idx;
            idx_next.tri0_b     = b_idx;
            idx_next.tri0_c     = b_idx + 16'd1;
            idx_next.tri1_c     = a_idx + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_dly[0] <= idx_next;
            for (int k = 1; k < IDX_DLY; k++)
            begin
                idx_dly[k] <= idx_dly[k-1];
            end
            tex_dly[0] <= '{tex_u: ph.tex_u, tex_v: ph.tex_v};
            for (int k = 1; k < TEX_DLY; k++)
            begin
                tex_dly[k] <= tex_dly[k-1];
            end
        end
    end

    uvs_phase u_phase (
        .clk      (clk),
        .en       (en),
        .grid_row (grid_row),
        .grid_col (grid_col),
        .prec     (prec_eff),
        .result   (ph)
    );

    uvs_sine u_sin_theta (.clk(clk), .en(en), .phase(ph.theta), .result(st));
    uvs_sine u_cos_theta (.clk(clk), .en(en), .phase(ph.theta + uvs_pkg::QUARTER_TURN),
                          .result(ct));
    uvs_sine u_sin_phi   (.clk(clk), .en(en), .phase(ph.phi), .result(sp));
    uvs_sine u_cos_phi   (.clk(clk), .en(en), .phase(ph.phi + uvs_pkg::QUARTER_TURN),
                          .result(cp));

    assign mx_prod = 62'(ct.mag) * 62'(sp.mag) + 62'(uvs_pkg::Q30_ONE >> 1);
    assign mz_prod = 62'(st.mag) * 62'(sp.mag) + 62'(uvs_pkg::Q30_ONE >> 1);
    assign mx_next = mx_prod[60:30];
    assign mz_next = mz_prod[60:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= mx_next;
            mz_reg <= mz_next;
            my_reg <= cp.mag;
            nx_reg <= (ct.neg != sp.neg) && (mx_next != '0);
            nz_reg <= (st.neg != sp.neg) && (mz_next != '0);
            ny_reg <= cp.neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_axis_tdata[15:0]    <= to_coord(mx_reg, nx_reg);
            m_axis_tdata[31:16]   <= to_coord(my_reg, ny_reg);
            m_axis_tdata[47:32]   <= to_coord(mz_reg, nz_reg);
            m_axis_tdata[64:48]   <= tex_dly[TEX_DLY-1].tex_u;
            m_axis_tdata[81:65]   <= tex_dly[TEX_DLY-1].tex_v;
            m_axis_tdata[97:82]   <= idx_dly[IDX_DLY-1].tri0_a;
            m_axis_tdata[113:98]  <= idx_dly[IDX_DLY-1].tri0_b;
            m_axis_tdata[129:114] <= idx_dly[IDX_DLY-1].tri0_c;
            m_axis_tdata[145:130] <= idx_dly[IDX_DLY-1].tri0_a;
            m_axis_tdata[161:146] <= idx_dly[IDX_DLY-1].tri0_c;
            m_axis_tdata[177:162] <= idx_dly[IDX_DLY-1].tri1_c;
            m_axis_tdata[183:178] <= '0;
            m_axis_tuser          <= idx_dly[IDX_DLY-1].quad_valid;
        end
    end

    // no quad means all six indices are zero
    a_no_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[177:82] == '0)
        else $error("indices nonzero without quad");

    // second triangle repeats vertices a and c of the first triangle
    a_tri_shared: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[145:130] == m_axis_tdata[97:82]
                       && m_axis_tdata[161:146] == m_axis_tdata[129:114])
        else $error("shared triangle vertices differ");

    // a held output beat freezes the valid pipeline
    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(v_reg))
        else $error("pipeline moved during output stall");

    // an accepted beat enters the valid pipeline
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v_reg[0])
        else $error("accepted beat lost");

endmodule

// ----- hdl/uvs_div.sv -----
// pipelined 16 by 8 bit restoring divider, two quotient bits per stage
// quotient must fit 8 bits; depends on nothing
`timescale 1ns / 1ps
module uvs_div (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] num,
    input  logic [7:0]  den,
    output logic [7:0]  quo
);

    localparam int STAGES = 4;

    logic [15:0] rem_reg [STAGES-1];
    logic [7:0]  den_reg [STAGES-1];
    logic [7:0]  quo_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [15:0] rem_in;
        logic [15:0] rem_mid;
        logic [15:0] rem_out;
        logic [7:0]  quo_in;
        logic [7:0]  quo_out;
        logic [7:0]  den_in;
        logic [15:0] div_hi;
        logic [15:0] div_lo;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        assign div_hi = 16'(den_in) << (7 - 2*s);
        assign div_lo = 16'(den_in) << (6 - 2*s);

        always_comb
        begin
            rem_mid = rem_in;
            quo_out = quo_in;
            if (rem_in >= div_hi)
            begin
                rem_mid            = rem_in - div_hi;
                quo_out[7 - 2*s]   = 1'b1;
            end
            rem_out = rem_mid;
            if (rem_mid >= div_lo)
            begin
                rem_out            = rem_mid - div_lo;
                quo_out[6 - 2*s]   = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= quo_out;
            end
        end

        if (s < STAGES-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_out;
                    den_reg[s] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[STAGES-1];

endmodule

// ----- hdl/uvs_phase.sv -----
// grid index to angle phase and texture coordinate, exact rounded division by precision
// depends on uvs_pkg and uvs_div
`timescale 1ns / 1ps
module uvs_phase (
    input  logic                 clk,
    input  logic                 en,
    input  logic [7:0]           grid_row,
    input  logic [7:0]           grid_col,
    input  logic [7:0]           prec,
    output uvs_pkg::phase_t      result
);

    localparam int DLY = 4;

    logic [7:0]  row_s1, col_s1, p_s1;
    logic [32:0] q32_s1, q31_s1, q16_s1;
    logic [7:0]  r32_s1, r31_s1, r16_s1;

    logic [40:0] th_full, ph_full, u_full, v_full;
    logic [7:0]  half;
    logic [15:0] n_th, n_ph, n_u, n_v;

    logic [31:0] th_s2, ph_s2;
    logic [24:0] u_s2, v_s2;
    logic [15:0] n_th_s2, n_ph_s2, n_u_s2, n_v_s2;
    logic [7:0]  p_s2;

    logic [31:0] th_dly [DLY];
    logic [31:0] ph_dly [DLY];
    logic [24:0] u_dly  [DLY];
    logic [24:0] v_dly  [DLY];

    logic [7:0]  quo_th, quo_ph, quo_u, quo_v;
    logic [25:0] u_sum, v_sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_s1 <= grid_row;
            col_s1 <= grid_col;
            p_s1   <= prec;
            q32_s1 <= uvs_pkg::QUOT32[prec];
            q31_s1 <= uvs_pkg::QUOT31[prec];
            q16_s1 <= uvs_pkg::QUOT16[prec];
            r32_s1 <= uvs_pkg::REM32[prec];
            r31_s1 <= uvs_pkg::REM31[prec];
            r16_s1 <= uvs_pkg::REM16[prec];
        end
    end

    // index * 2^k / p = index * floor(2^k/p) + (index * (2^k mod p) + p/2) / p
    assign half    = {1'b0, p_s1[7:1]};
    assign th_full = 41'(col_s1) * 41'(q32_s1);
    assign ph_full = 41'(row_s1) * 41'(q31_s1);
    assign u_full  = 41'(col_s1) * 41'(q16_s1);
    assign v_full  = 41'(row_s1) * 41'(q16_s1);
    assign n_th    = 16'(col_s1) * 16'(r32_s1) + 16'(half);
    assign n_ph    = 16'(row_s1) * 16'(r31_s1) + 16'(half);
    assign n_u     = 16'(col_s1) * 16'(r16_s1) + 16'(half);
    assign n_v     = 16'(row_s1) * 16'(r16_s1) + 16'(half);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_s2   <= th_full[31:0];
            ph_s2   <= ph_full[31:0];
            u_s2    <= u_full[24:0];
            v_s2    <= v_full[24:0];
            n_th_s2 <= n_th;
            n_ph_s2 <= n_ph;
            n_u_s2  <= n_u;
            n_v_s2  <= n_v;
            p_s2    <= p_s1;
        end
    end

    uvs_div u_div_th (.clk(clk), .en(en), .num(n_th_s2), .den(p_s2), .quo(quo_th));
    uvs_div u_div_ph (.clk(clk), .en(en), .num(n_ph_s2), .den(p_s2), .quo(quo_ph));
    uvs_div u_div_u  (.clk(clk), .en(en), .num(n_u_s2),  .den(p_s2), .quo(quo_u));
    uvs_div u_div_v  (.clk(clk), .en(en), .num(n_v_s2),  .den(p_s2), .quo(quo_v));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_dly[0] <= th_s2;
            ph_dly[0] <= ph_s2;
            u_dly[0]  <= u_s2;
            v_dly[0]  <= v_s2;
            for (int k = 1; k < DLY; k++)
            begin
                th_dly[k] <= th_dly[k-1];
                ph_dly[k] <= ph_dly[k-1];
                u_dly[k]  <= u_dly[k-1];
                v_dly[k]  <= v_dly[k-1];
            end
        end
    end

    assign u_sum = 26'(u_dly[DLY-1]) + 26'(quo_u);
    assign v_sum = 26'(v_dly[DLY-1]) + 26'(quo_v);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result.theta <= th_dly[DLY-1] + 32'(quo_th);
            result.phi   <= ph_dly[DLY-1] + 32'(quo_ph);
            result.tex_u <= (u_sum > 26'(uvs_pkg::TEX_MAX)) ? uvs_pkg::TEX_MAX : u_sum[16:0];
            result.tex_v <= (v_sum > 26'(uvs_pkg::TEX_MAX)) ? uvs_pkg::TEX_MAX : v_sum[16:0];
        end
    end

endmodule

// ----- hdl/uvs_sine.sv -----
// pipelined fixed point sine of a 32 bit turn phase: quadrant fold, taylor series in horner form
// depends on uvs_pkg
`timescale 1ns / 1ps
module uvs_sine (
    input  logic            clk,
    input  logic            en,
    input  logic [31:0]     phase,
    output uvs_pkg::sine_t  result
);

    localparam int STEPS = uvs_pkg::HORNER_STEPS;
    localparam logic [30:0] ONE = uvs_pkg::Q30_ONE;

    typedef struct packed {
        logic [31:0] a2;
        logic [30:0] a;
        logic        qhi;
    } carry_t;

    logic [30:0] f_s1;
    logic        qhi_s1;
    logic [61:0] aprod_s2;
    logic        qhi_s2;
    logic [30:0] a_s3;
    logic        qhi_s3;
    logic [61:0] a2prod_s4;
    logic [30:0] a_s4;
    logic        qhi_s4;
    carry_t      c_s5;

    logic [61:0] aprod_rnd, a2prod_rnd;
    logic [30:0] f_fold;

    carry_t      ca_reg [STEPS];
    carry_t      cb_reg [STEPS];
    carry_t      cc_reg [STEPS];
    logic [31:0] x_reg  [STEPS];
    logic [31:0] xb_reg [STEPS];
    logic [31:0] qe_reg [STEPS];
    logic [30:0] t_reg  [STEPS];

    logic [30:0] fy_reg;
    logic        fqhi_reg;
    logic [61:0] fprod;

    assign f_fold = phase[30] ? (ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_s1      <= f_fold;
            qhi_s1    <= phase[31];
            aprod_s2  <= 62'(f_s1) * 62'(uvs_pkg::HALF_PI_Q30);
            qhi_s2    <= qhi_s1;
            a_s3      <= aprod_rnd[60:30];
            qhi_s3    <= qhi_s2;
            a2prod_s4 <= 62'(a_s3) * 62'(a_s3);
            a_s4      <= a_s3;
            qhi_s4    <= qhi_s3;
            c_s5.a2   <= a2prod_rnd[61:30];
            c_s5.a    <= a_s4;
            c_s5.qhi  <= qhi_s4;
        end
    end

    assign aprod_rnd  = aprod_s2 + 62'(ONE >> 1);
    assign a2prod_rnd = a2prod_s4 + 62'(ONE >> 1);

    for (genvar k = 0; k < STEPS; k++)
    begin : g_horner
        localparam int unsigned DIV = uvs_pkg::HORNER_DIV[k];
        localparam int          SH  = 32 + $clog2(DIV + 1) - 1;
        localparam logic [63:0] MUL = (64'd1 << SH) / 64'(DIV);

        logic [30:0] t_in;
        carry_t      c_in;
        logic [62:0] xprod;
        logic [63:0] yprod;
        logic [63:0] back;
        logic [63:0] rem;
        logic [32:0] d;

        if (k == 0)
        begin : g_first
            assign t_in = ONE;
            assign c_in = c_s5;
        end
        else
        begin : g_next
            assign t_in = t_reg[k-1];
            assign c_in = cc_reg[k-1];
        end

        assign xprod = 63'(c_in.a2) * 63'(t_in);
        assign yprod = 64'(x_reg[k]) * 64'(MUL[31:0]);
        assign back  = 64'(qe_reg[k]) * 64'(DIV);
        assign rem   = 64'(xb_reg[k]) - back;
        assign d     = (rem >= 64'(DIV)) ? (33'(qe_reg[k]) + 33'd1) : 33'(qe_reg[k]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]  <= xprod[61:30];
                ca_reg[k] <= c_in;
                qe_reg[k] <= 32'(yprod >> SH);
                xb_reg[k] <= x_reg[k];
                cb_reg[k] <= ca_reg[k];
                t_reg[k]  <= (d >= 33'(ONE)) ? '0 : (ONE - d[30:0]);
                cc_reg[k] <= cb_reg[k];
            end
        end
    end

    assign fprod = 62'(cc_reg[STEPS-1].a) * 62'(t_reg[STEPS-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fy_reg     <= fprod[60:30];
            fqhi_reg   <= cc_reg[STEPS-1].qhi;
            result.mag <= (fy_reg > ONE) ? ONE : fy_reg;
            result.neg <= fqhi_reg && (fy_reg != '0);
        end
    end

endmodule
